@@ sv/tgi_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgi_pkg
// shared constants and types for the trilinear grid interpolator
// ----------------------------------------------------------------------------
package tgi_pkg;

    localparam int IDX_BITS   = 5;
    localparam int NODES      = 32;
    localparam int FRAC_BITS  = 16;
    localparam int POINT_BITS = 23;
    localparam int VALUE_BITS = 32;
    localparam int BANK_BITS  = 3 * (IDX_BITS - 1);
    localparam int BANK_DEPTH = 1 << BANK_BITS;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef logic [IDX_BITS-1:0]          idx_t;
    typedef logic [FRAC_BITS-1:0]         frac_t;
    typedef logic signed [VALUE_BITS-1:0] value_t;
    typedef logic [BANK_BITS-1:0]         bank_addr_t;

    typedef struct packed {
        logic  outside;
        frac_t fx;
        frac_t fy;
        frac_t fz;
    } qinfo_t;

endpackage

@@ sv/trilinear_grid_interpolator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trilinear_grid_interpolator
// node grid in eight parity banks and a pipelined trilinear interpolator
// ----------------------------------------------------------------------------
// channel  | handshake           | payload
// in       | in_valid / in_ready | op, point_x/y/z, node_x/y/z, node_value
// out      | out_valid/out_ready | value, out_of_box
// cfg      | cfg_we              | cfg_data (max_grid)
//
// one request per cycle while the output register is not stalled
// stage 0 decode and bank address, 1 bank read, 2 z steps, 3 y steps, 4 x step
// writes go straight into the banks and give no answer
// rst_n clears valid bits and sets max_grid to 31; the grid itself stays undefined
// the whole pipe holds while the output register is full and not taken
// ----------------------------------------------------------------------------
module trilinear_grid_interpolator (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                op,
    input  logic signed [tgi_pkg::POINT_BITS-1:0] point_x,
    input  logic signed [tgi_pkg::POINT_BITS-1:0] point_y,
    input  logic signed [tgi_pkg::POINT_BITS-1:0] point_z,
    input  tgi_pkg::idx_t                       node_x,
    input  tgi_pkg::idx_t                       node_y,
    input  tgi_pkg::idx_t                       node_z,
    input  tgi_pkg::value_t                     node_value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output tgi_pkg::value_t                     value,
    output logic                                out_of_box,
    input  logic                                cfg_we,
    input  tgi_pkg::idx_t                       cfg_data
);
    localparam int IB = tgi_pkg::IDX_BITS;

    tgi_pkg::idx_t   max_grid_reg;
    logic            adv;
    logic [3:0]      v_reg;
    logic            acc;

    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;
    assign acc      = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_grid_reg <= tgi_pkg::idx_t'(tgi_pkg::NODES - 1);
        end
        else if (cfg_we)
        begin
            max_grid_reg <= cfg_data;
        end
    end

    // stage 0: range check, corner indices
    logic signed [tgi_pkg::POINT_BITS-1:0] pts [3];
    logic          outside;
    tgi_pkg::idx_t lo [3];
    tgi_pkg::idx_t hi [3];
    tgi_pkg::frac_t fr [3];
    logic [tgi_pkg::POINT_BITS-1:0] top;

    always_comb
    begin
        pts[0]  = point_x;
        pts[1]  = point_y;
        pts[2]  = point_z;
        top     = tgi_pkg::POINT_BITS'({max_grid_reg, {tgi_pkg::FRAC_BITS{1'b0}}});
        outside = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            if (pts[i][tgi_pkg::POINT_BITS-1]
                || (pts[i] > $signed({1'b0, top[tgi_pkg::POINT_BITS-2:0]})))
            begin
                outside = 1'b1;
            end
            lo[i] = pts[i][tgi_pkg::FRAC_BITS +: IB];
            fr[i] = pts[i][tgi_pkg::FRAC_BITS-1:0];
            hi[i] = (lo[i] >= max_grid_reg) ? lo[i] : lo[i] + tgi_pkg::idx_t'(1);
        end
    end

    // bank b = {xpar,ypar,zpar}; each axis picks lo or hi by parity
    tgi_pkg::bank_addr_t raddr [8];
    always_comb
    begin
        for (int b = 0; b < 8; b++)
        begin
            tgi_pkg::idx_t cx, cy, cz;
            cx = (lo[0][0] == b[2]) ? lo[0] : hi[0];
            cy = (lo[1][0] == b[1]) ? lo[1] : hi[1];
            cz = (lo[2][0] == b[0]) ? lo[2] : hi[2];
            raddr[b] = {cx[IB-1:1], cy[IB-1:1], cz[IB-1:1]};
        end
    end

    logic we;
    assign we = acc && (op == tgi_pkg::OP_WRITE);

    tgi_pkg::value_t rdata [8];
    genvar g;
    generate
        for (g = 0; g < 8; g++)
        begin : g_bank
            tgi_bank u_bank (
                .clk   (clk),
                .we    (we && ({node_x[0], node_y[0], node_z[0]} == 3'(g))),
                .waddr ({node_x[IB-1:1], node_y[IB-1:1], node_z[IB-1:1]}),
                .wdata (node_value),
                .re    (adv),
                .raddr (raddr[g]),
                .rdata (rdata[g])
            );
        end
    endgenerate

    // per-stage side info
    tgi_pkg::qinfo_t q1_reg, q2_reg, q3_reg, q4_reg;
    logic [2:0] par1_reg;
    logic [2:0] eq1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[2:0], acc && (op == tgi_pkg::OP_QUERY)};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q1_reg   <= '{outside, fr[0], fr[1], fr[2]};
            par1_reg <= {lo[0][0], lo[1][0], lo[2][0]};
            eq1_reg  <= {hi[0] == lo[0], hi[1] == lo[1], hi[2] == lo[2]};
            q2_reg   <= q1_reg;
            q3_reg   <= q2_reg;
            q4_reg   <= q3_reg;
        end
    end

    // map banks to corners: corner {x,y,z} with 1 = hi; a clamped axis reads lo
    tgi_pkg::value_t cor [8];
    always_comb
    begin
        for (int c = 0; c < 8; c++)
        begin
            cor[c] = rdata[(3'(c) & ~eq1_reg) ^ par1_reg];
        end
    end

    tgi_pkg::value_t c00, c01, c10, c11, c0, c1, v;

    tgi_lerp u_z00 (.clk(clk), .en(adv), .a(cor[0]), .b(cor[1]), .f(q1_reg.fz), .y(c00));
    tgi_lerp u_z01 (.clk(clk), .en(adv), .a(cor[2]), .b(cor[3]), .f(q1_reg.fz), .y(c01));
    tgi_lerp u_z10 (.clk(clk), .en(adv), .a(cor[4]), .b(cor[5]), .f(q1_reg.fz), .y(c10));
    tgi_lerp u_z11 (.clk(clk), .en(adv), .a(cor[6]), .b(cor[7]), .f(q1_reg.fz), .y(c11));
    tgi_lerp u_y0  (.clk(clk), .en(adv), .a(c00), .b(c01), .f(q2_reg.fy), .y(c0));
    tgi_lerp u_y1  (.clk(clk), .en(adv), .a(c10), .b(c11), .f(q2_reg.fy), .y(c1));
    tgi_lerp u_x   (.clk(clk), .en(adv), .a(c0), .b(c1), .f(q3_reg.fx), .y(v));

    assign out_valid  = v_reg[3];
    assign value      = q4_reg.outside ? '0 : v;
    assign out_of_box = q4_reg.outside;
endmodule

@@ sv/tgi_lerp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgi_lerp
// one registered linear step a + rnd((b - a) * f / 2^frac), round half up
// ----------------------------------------------------------------------------
module tgi_lerp (
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [tgi_pkg::VALUE_BITS-1:0] a,
    input  logic signed [tgi_pkg::VALUE_BITS-1:0] b,
    input  tgi_pkg::frac_t                    f,
    output logic signed [tgi_pkg::VALUE_BITS-1:0] y
);
    localparam int DW = tgi_pkg::VALUE_BITS + 1;
    localparam int PW = DW + tgi_pkg::FRAC_BITS + 1;

    logic signed [DW-1:0] diff;
    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] rnd;
    logic signed [DW-1:0] step;
    logic signed [DW-1:0] sum;

    always_comb
    begin
        diff = DW'(b) - DW'(a);
        prod = PW'(diff) * $signed({1'b0, f});
        rnd  = prod + PW'(1 << (tgi_pkg::FRAC_BITS - 1));
        step = DW'(rnd >>> tgi_pkg::FRAC_BITS);
        sum  = DW'(a) + step;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y <= sum[tgi_pkg::VALUE_BITS-1:0];
        end
    end
endmodule

@@ sv/tgi_bank.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgi_bank
// one parity bank of the node grid, one write and one registered read port
// ----------------------------------------------------------------------------
module tgi_bank (
    input  logic                    clk,
    input  logic                    we,
    input  tgi_pkg::bank_addr_t     waddr,
    input  tgi_pkg::value_t         wdata,
    input  logic                    re,
    input  tgi_pkg::bank_addr_t     raddr,
    output tgi_pkg::value_t         rdata
);
    tgi_pkg::value_t mem [tgi_pkg::BANK_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

@@ sv/tgi_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgi_checker
// port-level checks for the trilinear grid interpolator
// ----------------------------------------------------------------------------
module tgi_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input tgi_pkg::value_t      value,
    input logic                 out_of_box
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(value))
        else $error("result dropped while stalled");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("request taken during stall");

    a_oob: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_of_box |-> value == '0)
        else $error("outside point with nonzero value");

    a_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("ready low with empty output");
endmodule

bind trilinear_grid_interpolator tgi_checker u_tgi_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .value      (value),
    .out_of_box (out_of_box)
);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the trilinear grid interpolator: node writes and
// point queries are predicted against a local grid copy and the answers are
// compared in order, under random idling on both channels
// ----------------------------------------------------------------------------
module testbench;

    typedef struct {
        logic                                  op;
        logic signed [tgi_pkg::POINT_BITS-1:0] px;
        logic signed [tgi_pkg::POINT_BITS-1:0] py;
        logic signed [tgi_pkg::POINT_BITS-1:0] pz;
        tgi_pkg::idx_t                         nx;
        tgi_pkg::idx_t                         ny;
        tgi_pkg::idx_t                         nz;
        tgi_pkg::value_t                       nv;
    } request_t;

    typedef struct {
        tgi_pkg::value_t v;
        logic            oob;
    } answer_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic op = tgi_pkg::OP_WRITE;
    logic signed [tgi_pkg::POINT_BITS-1:0] point_x = '0;
    logic signed [tgi_pkg::POINT_BITS-1:0] point_y = '0;
    logic signed [tgi_pkg::POINT_BITS-1:0] point_z = '0;
    tgi_pkg::idx_t node_x = '0;
    tgi_pkg::idx_t node_y = '0;
    tgi_pkg::idx_t node_z = '0;
    tgi_pkg::value_t node_value = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    tgi_pkg::value_t value;
    logic out_of_box;
    logic cfg_we = 1'b0;
    tgi_pkg::idx_t cfg_data = '0;

    request_t        pending_requests[$];
    answer_t         expected_answers[$];
    tgi_pkg::value_t grid_shadow[int];
    tgi_pkg::idx_t   grid_top = 5'd31;
    int       errors = 0;
    int       n_queries = 0;
    int       n_outside = 0;
    int       n_writes = 0;
    int       n_answers = 0;
    logic     calm = 1'b0;
    logic     in_taken = 1'b0;
    int       in_gap = 0;
    int       out_gap = 0;

    trilinear_grid_interpolator u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .op(op), .point_x(point_x), .point_y(point_y), .point_z(point_z),
        .node_x(node_x), .node_y(node_y), .node_z(node_z), .node_value(node_value),
        .out_valid(out_valid), .out_ready(out_ready),
        .value(value), .out_of_box(out_of_box),
        .cfg_we(cfg_we), .cfg_data(cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int node_key(int x, int y, int z);
        return (x * tgi_pkg::NODES + y) * tgi_pkg::NODES + z;
    endfunction

    function automatic longint node_at(int x, int y, int z);
        tgi_pkg::value_t nv;
        nv = grid_shadow.exists(node_key(x, y, z)) ? grid_shadow[node_key(x, y, z)] : '0;
        return longint'(nv);
    endfunction

    function automatic longint blend(longint a, longint b, longint f);
        longint p;
        p = (b - a) * f + (longint'(1) << (tgi_pkg::FRAC_BITS - 1));
        return a + (p >>> tgi_pkg::FRAC_BITS);
    endfunction

    function automatic answer_t interpolate(request_t r);
        answer_t ans;
        longint pt[3];
        int lo[3];
        int hi[3];
        longint fr[3];
        longint topv;
        longint c00, c01, c10, c11, c0, c1, v;
        logic outside;
        outside = 1'b0;
        topv = longint'(grid_top) << tgi_pkg::FRAC_BITS;
        pt[0] = r.px;
        pt[1] = r.py;
        pt[2] = r.pz;
        for (int i = 0; i < 3; i++)
        begin
            if (pt[i] < 0 || pt[i] > topv)
                outside = 1'b1;
        end
        if (outside)
        begin
            ans.v = '0;
            ans.oob = 1'b1;
            return ans;
        end
        for (int i = 0; i < 3; i++)
        begin
            lo[i] = int'(pt[i] >>> tgi_pkg::FRAC_BITS);
            fr[i] = pt[i] & ((longint'(1) << tgi_pkg::FRAC_BITS) - 1);
            hi[i] = (lo[i] + 1 > grid_top) ? lo[i] : lo[i] + 1;
        end
        c00 = blend(node_at(lo[0], lo[1], lo[2]), node_at(lo[0], lo[1], hi[2]), fr[2]);
        c01 = blend(node_at(lo[0], hi[1], lo[2]), node_at(lo[0], hi[1], hi[2]), fr[2]);
        c10 = blend(node_at(hi[0], lo[1], lo[2]), node_at(hi[0], lo[1], hi[2]), fr[2]);
        c11 = blend(node_at(hi[0], hi[1], lo[2]), node_at(hi[0], hi[1], hi[2]), fr[2]);
        c0 = blend(c00, c01, fr[1]);
        c1 = blend(c10, c11, fr[1]);
        v = blend(c0, c1, fr[0]);
        if (v > 64'sd2147483647)
            v = 64'sd2147483647;
        if (v < -64'sd2147483648)
            v = -64'sd2147483648;
        ans.v = tgi_pkg::value_t'(v);
        ans.oob = 1'b0;
        return ans;
    endfunction

    // driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_taken)
                void'(pending_requests.pop_front());
            if (in_valid && !in_taken)
                ;
            else if (in_gap > 0)
            begin
                in_gap <= in_gap - 1;
                in_valid <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                in_gap <= $urandom_range(1, 13) - 1;
                in_valid <= 1'b0;
            end
            else if (pending_requests.size() > 0)
            begin
                in_valid <= 1'b1;
                op <= pending_requests[0].op;
                point_x <= pending_requests[0].px;
                point_y <= pending_requests[0].py;
                point_z <= pending_requests[0].pz;
                node_x <= pending_requests[0].nx;
                node_y <= pending_requests[0].ny;
                node_z <= pending_requests[0].nz;
                node_value <= pending_requests[0].nv;
            end
            else
                in_valid <= 1'b0;

            if (out_gap > 0)
            begin
                out_gap <= out_gap - 1;
                out_ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                out_gap <= $urandom_range(1, 13) - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // predictor on acceptance, checker on answers
    always @(posedge clk)
    begin
        in_taken = rst_n && in_valid && in_ready;
        if (in_taken)
        begin
            request_t r;
            r.op = op; r.px = point_x; r.py = point_y; r.pz = point_z;
            r.nx = node_x; r.ny = node_y; r.nz = node_z; r.nv = node_value;
            if (r.op == tgi_pkg::OP_WRITE)
            begin
                grid_shadow[node_key(r.nx, r.ny, r.nz)] = r.nv;
                n_writes++;
            end
            else
            begin
                answer_t a;
                a = interpolate(r);
                expected_answers.push_back(a);
                n_queries++;
                if (a.oob)
                    n_outside++;
            end
        end
        if (rst_n && out_valid && out_ready)
        begin
            n_answers++;
            if (expected_answers.size() == 0)
            begin
                $error("unexpected answer value=%0d out_of_box=%0b", value, out_of_box);
                errors++;
            end
            else
            begin
                answer_t e;
                e = expected_answers.pop_front();
                if (value !== e.v)
                begin
                    $error("value: expected %0d actual %0d", e.v, value);
                    errors++;
                end
                if (out_of_box !== e.oob)
                begin
                    $error("out_of_box: expected %0b actual %0b", e.oob, out_of_box);
                    errors++;
                end
            end
        end
    end

    // lim bounds points that read nodes, mg is the current grid top
    function automatic logic signed [tgi_pkg::POINT_BITS-1:0] rand_coord(int lim, int mg);
        int k;
        k = $urandom_range(0, 19);
        if (k == 0)
            return tgi_pkg::POINT_BITS'(-$urandom_range(1, 4194304));
        if (k == 1)
            return tgi_pkg::POINT_BITS'($urandom_range((mg << tgi_pkg::FRAC_BITS) + 1, 4194303));
        if (k == 2)
            return tgi_pkg::POINT_BITS'(lim << tgi_pkg::FRAC_BITS);
        if (k == 3)
            return tgi_pkg::POINT_BITS'($urandom_range(0, lim) << tgi_pkg::FRAC_BITS);
        if (k == 4)
            return '0;
        return tgi_pkg::POINT_BITS'($urandom_range(0, lim << tgi_pkg::FRAC_BITS));
    endfunction

    function automatic tgi_pkg::value_t rand_value();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return tgi_pkg::value_t'($urandom_range(0, 255) - 128);
            default: return tgi_pkg::value_t'($urandom);
        endcase
    endfunction

    task automatic add_write(int x, int y, int z, tgi_pkg::value_t nv);
        request_t r;
        r.op = tgi_pkg::OP_WRITE;
        r.px = tgi_pkg::POINT_BITS'($urandom);
        r.py = tgi_pkg::POINT_BITS'($urandom);
        r.pz = tgi_pkg::POINT_BITS'($urandom);
        r.nx = tgi_pkg::idx_t'(x);
        r.ny = tgi_pkg::idx_t'(y);
        r.nz = tgi_pkg::idx_t'(z);
        r.nv = nv;
        pending_requests.push_back(r);
    endtask

    task automatic add_query(logic signed [tgi_pkg::POINT_BITS-1:0] x,
                             logic signed [tgi_pkg::POINT_BITS-1:0] y,
                             logic signed [tgi_pkg::POINT_BITS-1:0] z);
        request_t r;
        r.op = tgi_pkg::OP_QUERY;
        r.px = x; r.py = y; r.pz = z;
        r.nx = tgi_pkg::idx_t'($urandom);
        r.ny = tgi_pkg::idx_t'($urandom);
        r.nz = tgi_pkg::idx_t'($urandom);
        r.nv = tgi_pkg::value_t'($urandom);
        pending_requests.push_back(r);
    endtask

    // the grid is filled up to the current top first so no query reads an unset node
    task automatic fill_grid(int top);
        for (int x = 0; x <= top; x++)
            for (int y = 0; y <= top; y++)
                for (int z = 0; z <= top; z++)
                    add_write(x, y, z, rand_value());
    endtask

    task automatic drain_and_set(tgi_pkg::idx_t mg);
        while (pending_requests.size() > 0 || in_valid || expected_answers.size() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        @(negedge clk);
        cfg_data <= mg;
        cfg_we <= 1'b1;
        @(negedge clk);
        cfg_we <= 1'b0;
        grid_top = mg;
    endtask

    initial
    begin
        tgi_pkg::idx_t settings[6];
        int top;
        int lim;
        settings = '{5'd31, 5'd0, 5'd1, 5'd3, 5'd2, 5'd31};
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: small corner cube at the reset top
        for (int x = 0; x < 2; x++)
            for (int y = 0; y < 2; y++)
                for (int z = 0; z < 2; z++)
                    add_write(x, y, z, (x + y + z == 0) ? 32'sh7fffffff : 32'sh80000000);
        add_write(31, 31, 31, 32'sh12345678);
        add_query(0, 0, 0);
        add_query(23'sh8000, 23'sh8000, 23'sh8000);
        add_query(23'shffff, 23'sh1, 23'sh7fff);
        add_query(-23'sd1, 0, 0);
        add_query(0, 23'sh400000, 0);
        add_query(23'sh3fffff, 0, 0);
        add_query(31 << tgi_pkg::FRAC_BITS, 31 << tgi_pkg::FRAC_BITS,
                  31 << tgi_pkg::FRAC_BITS);
        add_query(0, 0, (31 << tgi_pkg::FRAC_BITS) + 1);

        foreach (settings[s])
        begin
            drain_and_set(settings[s]);
            top = settings[s];
            lim = (top <= 3) ? top : 2;
            if (top <= 3)
                fill_grid(top);
            else
                for (int x = 0; x <= 3; x++)
                    for (int y = 0; y <= 3; y++)
                        for (int z = 0; z <= 3; z++)
                            add_write(x, y, z, rand_value());
            if (s == 5)
                calm = 1'b1;
            for (int i = 0; i < 220; i++)
            begin
                if ($urandom_range(0, 4) == 0)
                    add_write($urandom_range(0, top < 3 ? top : 3),
                              $urandom_range(0, top < 3 ? top : 3),
                              $urandom_range(0, top < 3 ? top : 3), rand_value());
                else if (top > 3 && $urandom_range(0, 9) == 0)
                    add_query(tgi_pkg::POINT_BITS'($urandom_range(0, 4194303)),
                              tgi_pkg::POINT_BITS'(-$urandom_range(1, 4194304)),
                              tgi_pkg::POINT_BITS'($urandom_range(0, 4194303)));
                else
                    add_query(rand_coord(lim, top),
                              rand_coord(lim, top),
                              rand_coord(lim, top));
            end
        end
        while (pending_requests.size() > 0 || in_valid || expected_answers.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        $display("covered %0d node writes and %0d queries (%0d outside), %0d answers checked",
                 n_writes, n_queries, n_outside, n_answers);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("status: fail");
        $finish;
    end
endmodule
